@@ rtl/rmth_pkg.sv @@
// shared constants and types for the running median block
`default_nettype none
package rmth_pkg;
  localparam int unsigned HalfCapacity = 512;
  localparam int unsigned SampleWidth = 32;
  localparam int unsigned MedianWidth = 33;
  localparam int unsigned CountWidth = 11;
endpackage
`default_nettype wire

@@ rtl/running_median_two_heaps.sv @@
// running median over a stream of samples, kept as two heaps in ram
// usage:
//   input channel: sample_i with sample_valid_i, block drives sample_stall_o.
//   an item is accepted when valid is high and stall is low.
//   output channel: median_doubled_o, sample_count_o, dropped_full_o with
//   result_valid_o; the receiver drives result_stall_i.
//   each accepted sample gives exactly one result item: twice the median of
//   all held samples, the number held, and a flag when the store was full.
// sequence:
//   one item is worked at a time by a small sequencer around one shared
//   comparator and one ram port per heap. an item fetches the tops and
//   decides, sifts up level by level, then, if a top was replaced, sifts
//   down level by level, and rereads the tops to load the result. at 512
//   a sift walks at most nine levels each way. a new sample is not taken
//   until the last one has loaded its result; a dropped sample skips both
//   sifts. each level waits on the registered ram read.
// reset:
//   asynchronous, active low; both heap sizes go to zero, so no clearing pass.
//   ram contents are not cleared; only entries below the sizes are read.
// stall:
//   a finished result sits in the output register; the next sample is taken
//   while it waits, and the block holds at the result step until taken.
`default_nettype none
module running_median_two_heaps #(
  parameter int unsigned HALF_CAPACITY = rmth_pkg::HalfCapacity,
  parameter int unsigned SAMPLE_WIDTH  = rmth_pkg::SampleWidth
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               sample_valid_i,
  output logic                                    sample_stall_o,
  input  wire logic signed [31:0]                 sample_i,
  output logic                                    result_valid_o,
  input  wire logic                               result_stall_i,
  output logic signed [rmth_pkg::MedianWidth-1:0] median_doubled_o,
  output logic        [rmth_pkg::CountWidth-1:0]  sample_count_o,
  output logic                                    dropped_full_o
);
  localparam int unsigned AW = $clog2(HALF_CAPACITY);
  localparam int unsigned SW = $clog2(HALF_CAPACITY + 1);
  localparam logic [SW-1:0] FullSize = SW'(HALF_CAPACITY);
  localparam int unsigned MW = rmth_pkg::MedianWidth;
  localparam int unsigned CW = rmth_pkg::CountWidth;

  // sequencer states
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StTop    = 4'd1;  // read both tops
  localparam logic [3:0] StDecide = 4'd2;
  localparam logic [3:0] StUpRd   = 4'd3;  // sift-up: read parent
  localparam logic [3:0] StUpCmp  = 4'd4;
  localparam logic [3:0] StDnRdL  = 4'd5;  // sift-down: read left child
  localparam logic [3:0] StDnRdR  = 4'd6;
  localparam logic [3:0] StDnSel  = 4'd7;
  localparam logic [3:0] StDnCmp  = 4'd8;
  localparam logic [3:0] StMed    = 4'd9;  // reread tops for the median
  localparam logic [3:0] StOut    = 4'd10;

  logic [3:0]          state_q, state_d;
  logic [SW-1:0]       lsize_q, lsize_d, usize_q, usize_d;
  logic signed [SAMPLE_WIDTH-1:0] x_q, x_d;     // sample being placed
  logic signed [SAMPLE_WIDTH-1:0] v_q, v_d;     // value travelling in a sift
  logic signed [SAMPLE_WIDTH-1:0] c_q, c_d;     // best child value
  logic [AW-1:0]       i_q, i_d, cidx_q, cidx_d;
  logic                hs_q, hs_d;              // active heap: 1 lower (max)
  logic                dn_q, dn_d;              // sift-down pending after up
  logic                dnh_q, dnh_d;            // heap for pending sift-down
  logic                drop_q, drop_d;
  logic                rdrop_q, rdrop_d;        // drop flag of the held result
  logic                ovalid_q, ovalid_d;
  logic signed [MW-1:0] med_q, med_d;
  logic [CW-1:0]       cnt_q, cnt_d;

  // one address and data bus for both rams, write goes to the active heap
  logic                ram_we, lwe, uwe;
  logic [AW-1:0]       ram_addr;
  logic signed [SAMPLE_WIDTH-1:0] ram_wdata, lrdata, urdata, rd_act;

  logic [SW-1:0]       hsize;
  logic [AW:0]         lchild;
  logic [AW-1:0]       parent;
  logic                right_ok;

  // shared comparator: does a rank above b
  logic                cmp_max, cmp_above;
  logic signed [SAMPLE_WIDTH-1:0] cmp_a, cmp_b;

  rmth_ram #(.Width(SAMPLE_WIDTH), .Depth(HALF_CAPACITY)) u_lower (
    .clk_i, .we_i(lwe), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(lrdata)
  );
  rmth_ram #(.Width(SAMPLE_WIDTH), .Depth(HALF_CAPACITY)) u_upper (
    .clk_i, .we_i(uwe), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(urdata)
  );

  assign lwe = ram_we & hs_q;
  assign uwe = ram_we & ~hs_q;

  assign hsize    = hs_q ? lsize_q : usize_q;
  assign rd_act   = hs_q ? lrdata : urdata;
  assign lchild   = {i_q, 1'b1};
  assign parent   = (i_q - AW'(1)) >> 1;
  // right sibling of the left child at cidx exists
  assign right_ok = ({1'b0, cidx_q} + (AW+1)'(1)) < (AW+1)'(hsize);

  assign cmp_above = cmp_max ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

  // comparator operands per step
  always_comb begin
    cmp_max = hs_q;
    cmp_a   = v_q;
    cmp_b   = rd_act;
    unique case (state_q)
      StDecide: begin
        // sample against the lower top if the lower heap is fuller, else the upper top
        cmp_a = x_q;
        if (lsize_q > usize_q) begin
          cmp_max = 1'b1; cmp_b = lrdata;
        end else begin
          cmp_max = 1'b0; cmp_b = urdata;
        end
      end
      StDnSel: begin
        cmp_a = rd_act; cmp_b = c_q;
      end
      StDnCmp: begin
        cmp_a = c_q; cmp_b = v_q;
      end
      default: ;
    endcase
  end

  assign sample_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    lsize_d = lsize_q; usize_d = usize_q;
    x_d = x_q; v_d = v_q; c_d = c_q; i_d = i_q; cidx_d = cidx_q;
    hs_d = hs_q; dn_d = dn_q; dnh_d = dnh_q; drop_d = drop_q;
    rdrop_d = rdrop_q; ovalid_d = ovalid_q; med_d = med_q; cnt_d = cnt_q;
    ram_we = 1'b0; ram_addr = '0; ram_wdata = v_q;
    if (ovalid_q && !result_stall_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (sample_valid_i) begin
          x_d = sample_i[SAMPLE_WIDTH-1:0];
          state_d = StTop;
        end
      end
      StTop: begin
        state_d = StDecide;
      end
      StDecide: begin
        // pick target heap, value to insert, and optional top replacement, or drop when full
        drop_d = 1'b0;
        dn_d = 1'b0;
        if (lsize_q == '0) begin
          hs_d = 1'b1; v_d = x_q;
        end else if (lsize_q > usize_q) begin
          hs_d = 1'b0; dnh_d = 1'b1;
          if (cmp_above) begin
            v_d = x_q;
          end else begin
            // lower top moves up, sample replaces it
            v_d = lrdata; dn_d = 1'b1;
          end
        end else if (lsize_q >= FullSize) begin
          drop_d = 1'b1;
        end else begin
          hs_d = 1'b1; dnh_d = 1'b0;
          if (cmp_above) begin
            v_d = x_q;
          end else begin
            // upper top moves down, sample replaces it
            v_d = urdata; dn_d = 1'b1;
          end
        end
        if (drop_d) begin
          state_d = StMed;
        end else begin
          // hole at the tail, then walk up
          state_d = StUpRd;
          if (hs_d) begin
            i_d = lsize_q[AW-1:0]; lsize_d = lsize_q + SW'(1);
          end else begin
            i_d = usize_q[AW-1:0]; usize_d = usize_q + SW'(1);
          end
        end
      end
      StUpRd: begin
        if (i_q == '0) begin
          // reached the root
          ram_we = 1'b1; ram_addr = i_q; ram_wdata = v_q;
          if (dn_q) begin
            hs_d = dnh_q; i_d = '0; v_d = x_q; dn_d = 1'b0;
            state_d = StDnRdL;
          end else begin
            state_d = StMed;
          end
        end else begin
          ram_addr = parent;
          cidx_d = parent;
          state_d = StUpCmp;
        end
      end
      StUpCmp: begin
        // parent data valid now
        ram_we = 1'b1; ram_addr = i_q;
        if (cmp_above) begin
          // parent moves down into the hole
          ram_wdata = rd_act;
          i_d = cidx_q;
          state_d = StUpRd;
        end else begin
          ram_wdata = v_q;
          if (dn_q) begin
            hs_d = dnh_q; i_d = '0; v_d = x_q; dn_d = 1'b0;
            state_d = StDnRdL;
          end else begin
            state_d = StMed;
          end
        end
      end
      StDnRdL: begin
        if (lchild >= (AW+1)'(hsize)) begin
          // leaf: the value settles here
          ram_we = 1'b1; ram_addr = i_q; ram_wdata = v_q;
          state_d = StMed;
        end else begin
          ram_addr = lchild[AW-1:0];
          cidx_d = lchild[AW-1:0];
          state_d = StDnRdR;
        end
      end
      StDnRdR: begin
        c_d = rd_act;
        if (right_ok) begin
          ram_addr = cidx_q + AW'(1);
          state_d = StDnSel;
        end else begin
          state_d = StDnCmp;
        end
      end
      StDnSel: begin
        // right child data arrives: keep the better child
        if (cmp_above) begin
          c_d = rd_act; cidx_d = cidx_q + AW'(1);
        end
        state_d = StDnCmp;
      end
      StDnCmp: begin
        ram_we = 1'b1; ram_addr = i_q;
        if (cmp_above) begin
          // child moves up into the hole
          ram_wdata = c_q;
          i_d = cidx_q;
          state_d = StDnRdL;
        end else begin
          ram_wdata = v_q;
          state_d = StMed;
        end
      end
      StMed: begin
        state_d = StOut;
      end
      StOut: begin
        if (!ovalid_q || !result_stall_i) begin
          if (lsize_q > usize_q) begin
            med_d = MW'(lrdata) <<< 1;
          end else begin
            med_d = MW'(lrdata) + MW'(urdata);
          end
          cnt_d = CW'({1'b0, lsize_q} + {1'b0, usize_q});
          rdrop_d = drop_q;
          ovalid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      lsize_q <= '0;
      usize_q <= '0;
      ovalid_q <= 1'b0;
      dn_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lsize_q <= lsize_d;
      usize_q <= usize_d;
      ovalid_q <= ovalid_d;
      dn_q <= dn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; v_q <= v_d; c_q <= c_d; i_q <= i_d; cidx_q <= cidx_d;
    hs_q <= hs_d; dnh_q <= dnh_d; drop_q <= drop_d; rdrop_q <= rdrop_d;
    med_q <= med_d; cnt_q <= cnt_d;
  end

  assign result_valid_o   = ovalid_q;
  assign median_doubled_o = med_q;
  assign sample_count_o   = cnt_q;
  assign dropped_full_o   = rdrop_q;
endmodule
`default_nettype wire

@@ rtl/rmth_ram.sv @@
// generic single port ram with registered read
`default_nettype none
module rmth_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ rtl/rmth_checker.sv @@
// port-level checks for the running median block
`default_nettype none
module rmth_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        sample_valid_i,
  input wire logic        sample_stall_o,
  input wire logic        result_valid_o,
  input wire logic        result_stall_i,
  input wire logic [10:0] sample_count_o,
  input wire logic        dropped_full_o
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=> result_valid_o && $stable(sample_count_o))
    else $error("result changed under stall");
  // an accepted item keeps the block busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && !sample_stall_o |=> sample_stall_o)
    else $error("not busy after accept");
  // a dropped sample never reports an empty store
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && dropped_full_o |-> sample_count_o != 11'd0)
    else $error("drop with empty count");
  // results never report an empty store
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> sample_count_o != 11'd0)
    else $error("zero count");
endmodule
bind running_median_two_heaps rmth_checker u_rmth_checker (
  .clk_i, .rst_ni, .sample_valid_i, .sample_stall_o, .result_valid_o,
  .result_stall_i, .sample_count_o, .dropped_full_o
);
`default_nettype wire
